// File: rtl/ssfr_pkg.sv
// Shared constants and types for the sync-hunting stuffed frame receiver.
`default_nettype none

package ssfr_pkg;

    localparam logic [7:0] SYNC_BYTE  = 8'hFF;
    localparam logic [7:0] STUFF_BYTE = 8'h55;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_HUNT = 2'd0,
        MODE_READ = 2'd1,
        MODE_DONE = 2'd2
    } t_mode;

    typedef struct packed {
        logic [7:0] index;
        logic [7:0] data;
        logic [7:0] adjust;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic [QUEUE_CW-1:0] count;
        logic                full;
        logic                empty;
    } t_q_status;

endpackage

`default_nettype wire

// File: rtl/ssfr_if.sv
// Valid/ready channel interfaces for the received bytes and the buffer writes.
`default_nettype none

interface ssfr_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface ssfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] write_index;
    logic [7:0] write_value;
    logic       frame_done;

    modport source (output valid, output write_index, output write_value,
                    output frame_done, input ready);
    modport sink   (input valid, input write_index, input write_value,
                    input frame_done, output ready);
endinterface

`default_nettype wire

// File: rtl/ssfr_front.sv
// Front end: byte window, sync hunt, stuffing removal and write classification.
`default_nettype none

module ssfr_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    ssfr_in_if.sink                   i_in,
    input  wire ssfr_pkg::t_q_status  i_q_status,
    output logic                      o_push,
    output ssfr_pkg::t_cmd            o_cmd,
    output ssfr_pkg::t_mode           o_mode
);

    ssfr_pkg::t_mode r_mode, n_mode;
    logic [7:0] r_prev, n_prev;
    logic [7:0] r_cur, n_cur;
    logic [7:0] r_ptr, n_ptr;
    logic [7:0] r_len, n_len;
    logic [7:0] r_adj, n_adj;

    logic       w_fire;
    logic       w_byte;
    logic [7:0] w_b;
    logic       w_sync;
    logic       w_first;
    logic [7:0] w_len;
    logic       w_after_ff;
    logic       w_stuff;
    logic       w_restart;
    logic       w_emit;
    logic       w_last;

    assign i_in.ready = !i_q_status.full;
    assign w_fire     = i_in.valid && i_in.ready;
    assign w_byte     = w_fire && (i_in.opcode == ssfr_pkg::OP_BYTE);
    assign w_b        = i_in.rx_byte;

    assign w_sync     = (w_b == ssfr_pkg::SYNC_BYTE) && (r_cur == ssfr_pkg::SYNC_BYTE);
    assign w_first    = (r_ptr == 8'd0);
    assign w_len      = w_first ? w_b : r_len;
    assign w_after_ff = (r_cur == ssfr_pkg::SYNC_BYTE);
    assign w_stuff    = !w_first && w_after_ff && (w_b == ssfr_pkg::STUFF_BYTE);
    assign w_restart  = !w_first && w_after_ff && (w_b == ssfr_pkg::SYNC_BYTE);
    assign w_emit     = w_byte && (r_mode == ssfr_pkg::MODE_READ) && !w_stuff && !w_restart;
    assign w_last     = !(r_ptr < w_len);

    always_comb begin
        n_mode = r_mode;
        if (w_fire) begin
            if (i_in.opcode == ssfr_pkg::OP_RELEASE) begin
                n_mode = ssfr_pkg::MODE_HUNT;
            end else begin
                case (r_mode)
                    ssfr_pkg::MODE_HUNT: begin
                        if (w_sync) begin
                            n_mode = ssfr_pkg::MODE_READ;
                        end
                    end
                    ssfr_pkg::MODE_READ: begin
                        if (w_emit && w_last) begin
                            n_mode = ssfr_pkg::MODE_DONE;
                        end
                    end
                    default: begin
                        n_mode = r_mode;
                    end
                endcase
            end
        end
    end

    always_comb begin
        n_prev = r_prev;
        n_cur  = r_cur;
        n_ptr  = r_ptr;
        n_len  = r_len;
        n_adj  = r_adj;
        if (w_byte) begin
            n_prev = r_cur;
            n_cur  = w_b;
            case (r_mode)
                ssfr_pkg::MODE_HUNT: begin
                    if (w_sync) begin
                        n_ptr  = 8'd0;
                        n_prev = 8'd0;
                        n_cur  = 8'd0;
                    end
                end
                ssfr_pkg::MODE_READ: begin
                    if (w_first) begin
                        n_len = w_b;
                        n_adj = 8'd0;
                    end
                    if (w_stuff && (r_ptr <= r_len)) begin
                        n_adj = r_adj - ssfr_pkg::STUFF_BYTE;
                    end
                    if (w_restart) begin
                        n_ptr  = 8'd0;
                        n_prev = 8'd0;
                        n_cur  = 8'd0;
                    end
                    if (w_emit && !w_last) begin
                        n_ptr = r_ptr + 8'd1;
                    end
                end
                default: begin
                    n_ptr = r_ptr;
                end
            endcase
        end
    end

    always_comb begin
        o_push       = w_emit;
        o_cmd.index  = r_ptr;
        o_cmd.data   = w_b;
        o_cmd.adjust = w_first ? 8'd0 : r_adj;
        o_cmd.last   = w_last;
        o_mode       = r_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ssfr_pkg::MODE_HUNT;
            r_prev <= 8'd0;
            r_cur  <= 8'd0;
            r_ptr  <= 8'd0;
            r_len  <= 8'd0;
            r_adj  <= 8'd0;
        end else begin
            r_mode <= n_mode;
            r_prev <= n_prev;
            r_cur  <= n_cur;
            r_ptr  <= n_ptr;
            r_len  <= n_len;
            r_adj  <= n_adj;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ssfr_queue.sv
// Short queue of classified write commands between the front and back ends.
`default_nettype none

module ssfr_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire ssfr_pkg::t_cmd       i_cmd,
    input  wire logic                 i_pop,
    output ssfr_pkg::t_cmd            o_head,
    output ssfr_pkg::t_q_status       o_status
);

    ssfr_pkg::t_cmd r_mem [ssfr_pkg::QUEUE_DEPTH];

    logic [ssfr_pkg::QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [ssfr_pkg::QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [ssfr_pkg::QUEUE_CW-1:0] r_count, n_count;

    localparam logic [ssfr_pkg::QUEUE_AW-1:0] LAST_SLOT =
        ssfr_pkg::QUEUE_AW'(ssfr_pkg::QUEUE_DEPTH - 1);
    localparam logic [ssfr_pkg::QUEUE_CW-1:0] FULL_COUNT =
        ssfr_pkg::QUEUE_CW'(ssfr_pkg::QUEUE_DEPTH);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.count = r_count;
    assign o_status.full  = (r_count == FULL_COUNT);
    assign o_status.empty = (r_count == '0);

endmodule

`default_nettype wire

// File: rtl/ssfr_back.sv
// Back end: applies the checksum adjustment and holds the output register.
`default_nettype none

module ssfr_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ssfr_pkg::t_cmd       i_head,
    input  wire ssfr_pkg::t_q_status  i_q_status,
    output logic                      o_pop,
    ssfr_out_if.source                o_out
);

    logic       r_valid, n_valid;
    logic [7:0] r_index;
    logic [7:0] r_value;
    logic       r_done;
    logic       w_load;

    assign w_load = !i_q_status.empty && (!r_valid || o_out.ready);
    assign o_pop  = w_load;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_index <= i_head.index;
            r_value <= i_head.last ? (i_head.data + i_head.adjust) : i_head.data;
            r_done  <= i_head.last;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.write_index = r_index;
    assign o_out.write_value = r_value;
    assign o_out.frame_done  = r_done;

endmodule

`default_nettype wire

// File: rtl/sync_stuffed_frame_receiver.sv
// Sync-hunting byte-stuffed frame receiver: top level.
//
// The input channel carries one transaction per received serial byte
// (opcode byte) or per release of a finished frame (opcode release). The
// output channel carries one transaction per frame buffer write: the
// position, the byte stored, and a flag on the write that completes a frame.
// Sync pairs, stuffing bytes, restarts, release transactions and bytes seen
// while hunting or after a finished frame give no output transaction.
// The block accepts one input transaction every cycle while the queue is not
// full. The front end classifies each accepted byte and pushes a command into
// a two-entry queue as it is accepted; the back end moves the head into the
// output register when that register is empty or its transaction is taken.
// When the receiver holds ready low, the output register holds its
// transaction, the queue fills, and input ready drops once both queue
// entries are taken; input ready depends only on the queue fill count.
// Reset is synchronous and active low: it empties the queue and the output
// register, clears the byte window, pointer, length and adjustment, and
// sets the front end to hunt for the sync pair.
`default_nettype none

module sync_stuffed_frame_receiver (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ssfr_in_if.sink    i_in,
    ssfr_out_if.source o_out
);

    logic                w_push;
    logic                w_pop;
    ssfr_pkg::t_cmd      w_cmd;
    ssfr_pkg::t_cmd      w_head;
    ssfr_pkg::t_q_status w_q_status;
    ssfr_pkg::t_mode     w_mode;

    ssfr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_cmd      (w_cmd),
        .o_mode     (w_mode)
    );

    ssfr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_cmd),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    ssfr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_out      (o_out)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.count <= ssfr_pkg::QUEUE_CW'(ssfr_pkg::QUEUE_DEPTH))
        else $error("Queue count exceeds its depth.");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("Queue popped while empty.");

    a_push_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_mode == ssfr_pkg::MODE_READ))
        else $error("Buffer write issued outside a frame.");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_cmd.last) |=> (w_mode == ssfr_pkg::MODE_DONE))
        else $error("Final write did not finish the frame.");

endmodule

`default_nettype wire
